@@ rtl/crf_pkg.sv @@
// Shared constants and the frame result type for the checksummed frame receiver.
package crf_pkg;

  localparam int unsigned BYTE_W          = 8;
  localparam int unsigned LEN_W           = 4;
  localparam int unsigned PAYLOAD_LANES   = 8;
  localparam int unsigned PAYLOAD_W       = PAYLOAD_LANES * BYTE_W;
  localparam int unsigned MAX_PAYLOAD_DEF = 8;

  localparam logic [BYTE_W-1:0] HEADER_BYTE = 8'hAA;

  typedef struct packed {
    logic                 buffer_slot;
    logic [BYTE_W-1:0]    direction;
    logic [BYTE_W-1:0]    msg_ref;
    logic [BYTE_W-1:0]    opcode;
    logic [LEN_W-1:0]     payload_len;
    logic [PAYLOAD_W-1:0] payload;
  } frame_t;

endpackage

@@ rtl/crf_if.sv @@
// Valid/ready channel interfaces: received bytes in, checked frames out.
interface crf_byte_if;
  logic                      valid;
  logic                      ready;
  logic [crf_pkg::BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface crf_frame_if;
  logic                          valid;
  logic                          ready;
  logic                          buffer_slot;
  logic [crf_pkg::BYTE_W-1:0]    direction;
  logic [crf_pkg::BYTE_W-1:0]    msg_ref;
  logic [crf_pkg::BYTE_W-1:0]    opcode;
  logic [crf_pkg::LEN_W-1:0]     payload_len;
  logic [crf_pkg::PAYLOAD_W-1:0] payload;

  modport source (output valid, output buffer_slot, output direction, output msg_ref,
                  output opcode, output payload_len, output payload, input ready);
  modport sink   (input valid, input buffer_slot, input direction, input msg_ref,
                  input opcode, input payload_len, input payload, output ready);
endinterface

@@ rtl/crf_inreg.sv @@
// Input register stage: holds one received byte until the parser takes it.
module crf_inreg (
  input  logic                       clk,
  input  logic                       rst,
  crf_byte_if.sink                   rx,
  input  logic                       take,
  output logic                       vld,
  output logic [crf_pkg::BYTE_W-1:0] data
);

  assign rx.ready = !vld || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (rx.ready) begin
      vld <= rx.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.ready && rx.valid) begin
      data <= rx.rx_byte;
    end
  end

endmodule

@@ rtl/crf_parse.sv @@
// Frame parser: phase sequencer, running sum, payload store and result build.
module crf_parse #(
  parameter int unsigned MAX_PAYLOAD = crf_pkg::MAX_PAYLOAD_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       take,
  input  logic [crf_pkg::BYTE_W-1:0] rx_byte,
  output logic                       res_vld,
  output crf_pkg::frame_t            res
);

  localparam int unsigned IDX_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam logic [crf_pkg::BYTE_W-1:0] MAX_LEN = crf_pkg::BYTE_W'(MAX_PAYLOAD);

  typedef enum logic [2:0] {
    PH_HUNT = 3'd0,
    PH_DIR  = 3'd1,
    PH_REF  = 3'd2,
    PH_CMD  = 3'd3,
    PH_LEN  = 3'd4,
    PH_DATA = 3'd5,
    PH_SUM  = 3'd6
  } phase_t;

  phase_t                     phase;
  logic [crf_pkg::BYTE_W-1:0] dir_reg;
  logic [crf_pkg::BYTE_W-1:0] ref_reg;
  logic [crf_pkg::BYTE_W-1:0] op_reg;
  logic [crf_pkg::LEN_W-1:0]  len_reg;
  logic [crf_pkg::LEN_W-1:0]  byte_index;
  logic [crf_pkg::BYTE_W-1:0] running_sum;
  logic                       slot_toggle;
  logic [crf_pkg::BYTE_W-1:0] store [MAX_PAYLOAD];

  logic [crf_pkg::LEN_W-1:0]  index_next;
  logic [crf_pkg::BYTE_W-1:0] sum_next;
  logic [crf_pkg::PAYLOAD_W-1:0] packed_payload;

  assign index_next = byte_index + crf_pkg::LEN_W'(1);
  assign sum_next   = running_sum + rx_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_HUNT;
      dir_reg     <= '0;
      ref_reg     <= '0;
      op_reg      <= '0;
      len_reg     <= '0;
      byte_index  <= '0;
      running_sum <= '0;
      slot_toggle <= 1'b0;
    end else if (take) begin
      case (phase)
        PH_DIR: begin
          dir_reg     <= rx_byte;
          running_sum <= sum_next;
          phase       <= PH_REF;
        end
        PH_REF: begin
          ref_reg     <= rx_byte;
          running_sum <= sum_next;
          phase       <= PH_CMD;
        end
        PH_CMD: begin
          op_reg      <= rx_byte;
          running_sum <= sum_next;
          phase       <= PH_LEN;
        end
        PH_LEN: begin
          if (rx_byte > MAX_LEN) begin
            // oversize length: drop the frame, byte is not a header candidate
            phase <= PH_HUNT;
          end else begin
            len_reg     <= rx_byte[crf_pkg::LEN_W-1:0];
            byte_index  <= '0;
            running_sum <= sum_next;
            phase       <= (rx_byte == '0) ? PH_SUM : PH_DATA;
          end
        end
        PH_DATA: begin
          running_sum <= sum_next;
          byte_index  <= index_next;
          if (index_next >= len_reg) begin
            phase <= PH_SUM;
          end
        end
        PH_SUM: begin
          if (res_vld) begin
            slot_toggle <= !slot_toggle;
          end
          phase <= PH_HUNT;
        end
        default: begin
          phase <= PH_HUNT;
          if (rx_byte == crf_pkg::HEADER_BYTE) begin
            running_sum <= rx_byte;
            phase       <= PH_DIR;
          end
        end
      endcase
    end
  end

  // payload bytes; only lanes below the frame length are ever read
  always_ff @(posedge clk) begin
    if (take && phase == PH_DATA) begin
      store[byte_index[IDX_W-1:0]] <= rx_byte;
    end
  end

  for (genvar k = 0; k < crf_pkg::PAYLOAD_LANES; k++) begin : g_lane
    if (k < MAX_PAYLOAD) begin : g_used
      assign packed_payload[k*crf_pkg::BYTE_W +: crf_pkg::BYTE_W] =
        (crf_pkg::LEN_W'(k) < len_reg) ? store[k] : '0;
    end else begin : g_unused
      assign packed_payload[k*crf_pkg::BYTE_W +: crf_pkg::BYTE_W] = '0;
    end
  end

  assign res_vld = (phase == PH_SUM) && (running_sum == rx_byte);

  always_comb begin
    res.buffer_slot = slot_toggle;
    res.direction   = dir_reg;
    res.msg_ref     = ref_reg;
    res.opcode      = op_reg;
    res.payload_len = len_reg;
    res.payload     = packed_payload;
  end

endmodule

@@ rtl/crf_outreg.sv @@
// Result register: holds a checked frame until the downstream side takes it.
module crf_outreg (
  input  logic            clk,
  input  logic            rst,
  input  logic            load,
  input  logic            res_vld,
  input  crf_pkg::frame_t res,
  output logic            free,
  crf_frame_if.source     frame
);

  logic            vld;
  crf_pkg::frame_t data;

  assign free = !vld || frame.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (load) begin
      vld <= res_vld;
    end else if (frame.ready) begin
      vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load && res_vld) begin
      data <= res;
    end
  end

  assign frame.valid       = vld;
  assign frame.buffer_slot = data.buffer_slot;
  assign frame.direction   = data.direction;
  assign frame.msg_ref     = data.msg_ref;
  assign frame.opcode      = data.opcode;
  assign frame.payload_len = data.payload_len;
  assign frame.payload     = data.payload;

endmodule

@@ rtl/checksummed_frame_receiver.sv @@
// Top level of the checksummed frame receiver: byte in, checked frame out.
//
//  port   | direction | carries per transfer
//  -------+-----------+-----------------------------------------------------
//  rx     | in        | rx_byte: one byte from the serial line
//  frame  | out       | buffer_slot, direction, msg_ref, opcode,
//         |           | payload_len, payload of one frame with a good checksum
//
//  One byte per cycle sustained while the result side does not stall. A byte is
//  registered at transfer, handled by the parser when it can advance, and a frame it
//  completes is held in the result register, from which it appears on frame.
//  rst is synchronous, active high; it returns the parser to the header hunt
//  and clears the ping-pong slot to zero.
//  A held result stalls the parser only while frame.ready is low; rx keeps
//  taking bytes into its register while the parser can advance.
module checksummed_frame_receiver #(
  parameter int unsigned MAX_PAYLOAD = crf_pkg::MAX_PAYLOAD_DEF
) (
  input  logic        clk,
  input  logic        rst,
  crf_byte_if.sink    rx,
  crf_frame_if.source frame
);

  logic                       in_vld;
  logic [crf_pkg::BYTE_W-1:0] in_byte;
  logic                       out_free;
  logic                       take;
  logic                       res_vld;
  crf_pkg::frame_t            res;

  // parser advances when a byte is staged and the result register can load
  assign take = in_vld && out_free;

  crf_inreg u_inreg (
    .clk  (clk),
    .rst  (rst),
    .rx   (rx),
    .take (take),
    .vld  (in_vld),
    .data (in_byte)
  );

  crf_parse #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_parse (
    .clk     (clk),
    .rst     (rst),
    .take    (take),
    .rx_byte (in_byte),
    .res_vld (res_vld),
    .res     (res)
  );

  crf_outreg u_outreg (
    .clk     (clk),
    .rst     (rst),
    .load    (take),
    .res_vld (res_vld),
    .res     (res),
    .free    (out_free),
    .frame   (frame)
  );

endmodule

@@ bench/testbench.sv @@
// Self-checking testbench for the checksummed frame receiver: byte stream in, checked frames out.
module testbench;

  localparam int unsigned MAX_LEN = crf_pkg::MAX_PAYLOAD_DEF;

  // Parser phases of the scoreboard's own copy of the receiver.
  typedef enum logic [2:0] {
    PH_HUNT,
    PH_DIR,
    PH_REF,
    PH_CMD,
    PH_LEN,
    PH_DATA,
    PH_SUM
  } parse_phase_t;

  logic clk;
  logic rst;

  crf_byte_if  rx_if ();
  crf_frame_if frame_if ();

  checksummed_frame_receiver #(
    .MAX_PAYLOAD(MAX_LEN)
  ) u_dut (
    .clk  (clk),
    .rst  (rst),
    .rx   (rx_if),
    .frame(frame_if)
  );

  // Parser state mirrored in the bench.
  parse_phase_t phase_q;
  logic [7:0]   dir_q;
  logic [7:0]   ref_q;
  logic [7:0]   op_q;
  logic [3:0]   len_q;
  logic [3:0]   lane_q;
  logic [7:0]   sum_q;
  logic [7:0]   lane_bytes [crf_pkg::PAYLOAD_LANES];
  logic         slot_q;

  crf_pkg::frame_t expected_frames [$];
  int           error_count;
  int           bytes_sent;
  int           burst_left;
  logic [31:0]  cycle_count;

  // 10-unit clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the receiver hangs or drops frames.
  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

  task automatic log_error(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    error_count++;
  endtask

  task automatic reset_parser_model();
    phase_q = PH_HUNT;
    dir_q   = '0;
    ref_q   = '0;
    op_q    = '0;
    len_q   = '0;
    lane_q  = '0;
    sum_q   = '0;
    slot_q  = 1'b0;
    foreach (lane_bytes[k]) lane_bytes[k] = '0;
  endtask

  // Advance the mirrored parser by one received byte. Returns 1 when the byte
  // closes a frame whose checksum matches; fr then holds the frame to expect.
  function automatic bit parse_byte(input logic [7:0] b, output crf_pkg::frame_t fr);
    bit done;
    done = 1'b0;
    fr   = '0;
    case (phase_q)
      PH_DIR: begin
        dir_q   = b;
        sum_q   = sum_q + b;
        phase_q = PH_REF;
      end
      PH_REF: begin
        ref_q   = b;
        sum_q   = sum_q + b;
        phase_q = PH_CMD;
      end
      PH_CMD: begin
        op_q    = b;
        sum_q   = sum_q + b;
        phase_q = PH_LEN;
      end
      PH_LEN: begin
        // Oversized length: frame dropped, byte not summed and not a header.
        if (b > MAX_LEN) begin
          phase_q = PH_HUNT;
        end else begin
          len_q   = b[3:0];
          lane_q  = '0;
          sum_q   = sum_q + b;
          phase_q = (b == 8'd0) ? PH_SUM : PH_DATA;
        end
      end
      PH_DATA: begin
        lane_bytes[lane_q[2:0]] = b;
        sum_q  = sum_q + b;
        lane_q = lane_q + 4'd1;
        if (lane_q >= len_q) phase_q = PH_SUM;
      end
      PH_SUM: begin
        // The byte closing a frame is never retried as a header.
        if (sum_q == b) begin
          fr.buffer_slot = slot_q;
          fr.direction   = dir_q;
          fr.msg_ref     = ref_q;
          fr.opcode      = op_q;
          fr.payload_len = len_q;
          for (int k = 0; k < crf_pkg::PAYLOAD_LANES; k++) begin
            if (k < len_q) fr.payload[8*k +: 8] = lane_bytes[k];
          end
          slot_q = ~slot_q;
          done   = 1'b1;
        end
        phase_q = PH_HUNT;
      end
      default: begin
        phase_q = PH_HUNT;
        if (b == crf_pkg::HEADER_BYTE) begin
          sum_q   = b;
          phase_q = PH_DIR;
        end
      end
    endcase
    return done;
  endfunction

  // Send one byte. Called right after a rising edge; returns at the edge of
  // the transfer with valid still high, so a following call keeps the stream
  // gap-free. Bursts of random length are separated by random gaps.
  task automatic send_byte(input logic [7:0] b);
    int              gap;
    crf_pkg::frame_t fr;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        rx_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    rx_if.valid   <= 1'b1;
    rx_if.rx_byte <= b;
    do begin
      @(posedge clk);
    end while (rx_if.ready !== 1'b1);
    bytes_sent++;
    if (parse_byte(b, fr)) expected_frames.push_back(fr);
  endtask

  // Header, fields, length, payload and checksum; payload and checksum only when len is
  // at most MAX_LEN. sum_err is added to the correct checksum (zero gives a good frame);
  // only the first cut bytes go out, which truncates a frame when cut is short.
  task automatic send_frame(input logic [7:0] dir, input logic [7:0] msgref,
                            input logic [7:0] op, input logic [7:0] len,
                            input logic [63:0] data, input logic [7:0] sum_err,
                            input int cut);
    logic [7:0] seq [$];
    logic [7:0] sum;
    seq.push_back(crf_pkg::HEADER_BYTE);
    seq.push_back(dir);
    seq.push_back(msgref);
    seq.push_back(op);
    seq.push_back(len);
    if (len <= MAX_LEN) begin
      for (int k = 0; k < len; k++) seq.push_back(data[8*k +: 8]);
      sum = '0;
      foreach (seq[k]) sum = sum + seq[k];
      seq.push_back(sum + sum_err);
    end
    foreach (seq[k]) begin
      if (k < cut) send_byte(seq[k]);
    end
  endtask

  // Stop sending and wait for every expected frame, then wait on so that any late
  // frame still in the input and result registers can come out.
  task automatic drain_frames();
    int waited;
    waited = 0;
    rx_if.valid <= 1'b0;
    while (expected_frames.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (16) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_field();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Receiver stall pattern, switching with cycle_count bits 9:8 between always ready,
  // coin flip, mostly stalled and a fixed 5-of-8 duty cycle.
  function automatic logic pick_ready();
    case (cycle_count[9:8])
      2'd0:    return 1'b1;
      2'd1:    return $urandom_range(0, 1) == 1;
      2'd2:    return $urandom_range(0, 3) == 0;
      default: return cycle_count[2:0] < 3'd5;
    endcase
  endfunction

  task automatic check_frame();
    crf_pkg::frame_t want;
    if (expected_frames.size() == 0) begin
      log_error($sformatf("unexpected frame dir=%02h ref=%02h op=%02h len=%0d",
                          frame_if.direction, frame_if.msg_ref, frame_if.opcode,
                          frame_if.payload_len));
    end else begin
      want = expected_frames.pop_front();
      if (frame_if.buffer_slot !== want.buffer_slot)
        log_error($sformatf("buffer_slot %0b, expected %0b",
                            frame_if.buffer_slot, want.buffer_slot));
      if (frame_if.direction !== want.direction)
        log_error($sformatf("direction %02h, expected %02h",
                            frame_if.direction, want.direction));
      if (frame_if.msg_ref !== want.msg_ref)
        log_error($sformatf("msg_ref %02h, expected %02h", frame_if.msg_ref, want.msg_ref));
      if (frame_if.opcode !== want.opcode)
        log_error($sformatf("opcode %02h, expected %02h", frame_if.opcode, want.opcode));
      if (frame_if.payload_len !== want.payload_len)
        log_error($sformatf("payload_len %0d, expected %0d",
                            frame_if.payload_len, want.payload_len));
      if (frame_if.payload !== want.payload)
        log_error($sformatf("payload %016h, expected %016h",
                            frame_if.payload, want.payload));
    end
  endtask

  // Frame side: check each transfer against the oldest expectation, then
  // drive ready for the next cycle.
  initial begin
    cycle_count = '0;
    frame_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst === 1'b0 && frame_if.valid === 1'b1 && frame_if.ready === 1'b1)
        check_frame();
      frame_if.ready <= pick_ready();
      cycle_count = cycle_count + 32'd1;
    end
  end

  // Oversized length byte that also equals the header value: the frame is
  // dropped and that byte must not open a new frame.
  task automatic test_long_length_abort();
    send_frame(8'h12, 8'h34, 8'h56, crf_pkg::HEADER_BYTE, '0, 8'h00, 99);
  endtask

  // Zero length goes straight to the checksum; the checksum here is 0xAA,
  // which must close the frame, not start another.
  task automatic test_zero_length();
    send_frame(8'h00, 8'h00, 8'h00, 8'h00, '0, 8'h00, 99);
  endtask

  // Bad checksum equal to the header value: silent drop, no new frame.
  task automatic test_checksum_mismatch();
    send_frame(8'h01, 8'h00, 8'h00, 8'h00, '0, 8'hFF, 99);
  endtask

  // All-ones fields and the largest payload; this frame goes out in slot one.
  task automatic test_full_payload();
    send_frame(8'hFF, 8'hFF, 8'hFF, 8'(MAX_LEN), '1, 8'h00, 99);
  endtask

  // Mostly good frames with random content, plus bad checksums, oversized
  // lengths, truncated frames and loose noise bytes (which may hold 0xAA).
  // Four stretches, each ended by a full drain of the result side.
  task automatic test_random_traffic();
    int         kind;
    int         goal;
    int         cut;
    logic [7:0] len;
    logic [7:0] sum_err;
    for (int stretch = 0; stretch < 4; stretch++) begin
      goal = bytes_sent + 500;
      while (bytes_sent < goal) begin
        kind    = $urandom_range(0, 99);
        len     = 8'($urandom_range(0, MAX_LEN));
        sum_err = 8'h00;
        cut     = 99;
        if (kind >= 92) begin
          cut = $urandom_range(1, 5 + len);
        end else if (kind >= 85) begin
          len = 8'($urandom_range(MAX_LEN + 1, 255));
        end else if (kind >= 75) begin
          sum_err = 8'($urandom_range(1, 255));
        end
        send_frame(pick_field(), pick_field(), pick_field(), len,
                   {32'($urandom), 32'($urandom)}, sum_err, cut);
        if ($urandom_range(0, 3) == 0) begin
          repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)));
        end
      end
      drain_frames();
    end
  endtask

  initial begin
    error_count = 0;
    bytes_sent  = 0;
    burst_left  = 0;
    rst           <= 1'b1;
    rx_if.valid   <= 1'b0;
    rx_if.rx_byte <= '0;
    reset_parser_model();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_long_length_abort();
    test_zero_length();
    test_checksum_mismatch();
    test_full_payload();
    test_random_traffic();
    drain_frames();

    if (expected_frames.size() != 0)
      log_error($sformatf("%0d expected frames never arrived", expected_frames.size()));
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/crf_pkg.sv
rtl/crf_if.sv
rtl/crf_inreg.sv
rtl/crf_parse.sv
rtl/crf_outreg.sv
rtl/checksummed_frame_receiver.sv
bench/testbench.sv
